>>> src/j1850_pkg.sv
// Shared constants and field widths for the J1850 PWM frame receiver.
package j1850_pkg;

   // Ring geometry
   localparam int PACKET_SLOTS = 4;
   localparam int PACKET_BYTES = 16;
   localparam int SLOT_W       = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;
   localparam int BYTE_W       = $clog2(PACKET_BYTES);
   localparam int LEN_W        = $clog2(PACKET_BYTES + 1);
   localparam int ADDR_W       = SLOT_W + BYTE_W;
   localparam int MEM_DEPTH    = PACKET_SLOTS << BYTE_W;

   // Fixed field widths
   localparam int TICK_W   = 8;
   localparam int OP_W     = 3;
   localparam int STATE_W  = 3;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_RISE = 3'd0;
   localparam logic [OP_W-1:0] OP_FALL = 3'd1;
   localparam logic [OP_W-1:0] OP_EOD  = 3'd2;
   localparam logic [OP_W-1:0] OP_EOF  = 3'd3;
   localparam logic [OP_W-1:0] OP_IDLE = 3'd4;
   localparam logic [OP_W-1:0] OP_READ = 3'd5;

   // Bus states
   localparam logic [STATE_W-1:0] BUS_UNKNOWN = 3'd0;
   localparam logic [STATE_W-1:0] BUS_ERROR   = 3'd1;
   localparam logic [STATE_W-1:0] BUS_SOF     = 3'd2;
   localparam logic [STATE_W-1:0] BUS_DATA    = 3'd3;
   localparam logic [STATE_W-1:0] BUS_EOD     = 3'd4;
   localparam logic [STATE_W-1:0] BUS_EOF     = 3'd5;
   localparam logic [STATE_W-1:0] BUS_IDLE    = 3'd6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BIT_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOF_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOF_MAX = 3'd4;

   // Register reset values
   localparam logic [TICK_W-1:0] RST_BIT_MIN = 8'd14;
   localparam logic [TICK_W-1:0] RST_BIT_MAX = 8'd39;
   localparam logic [TICK_W-1:0] RST_ONE_MAX = 8'd24;
   localparam logic [TICK_W-1:0] RST_SOF_MIN = 8'd60;
   localparam logic [TICK_W-1:0] RST_SOF_MAX = 8'd66;

   // Bit counter value that completes a byte
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

>>> src/j1850_pwm_frame_receiver_top.sv
// Top level of the J1850 PWM frame receiver: event decoder, packet ring and read-out.
//
// Each bus event word (edge or timeout) is answered by one status word. A read word
// on a non-empty ring answers with one word per stored byte of the oldest packet
// (n bytes, n up to 16), streamed from the packet memory at one byte per cycle while
// the response side is ready; that memory has a single registered read port, and no
// new word is taken until the last byte has moved into the response register. A read
// on an empty ring, and the unused operation codes, answer with a status word only.
// Configuration writes are always taken. Packet bytes beyond sixteen overwrite the
// last byte; closing a packet onto the unread oldest one drops all unread packets.
module j1850_pwm_frame_receiver_top
   import j1850_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [7:0] elapsed_ticks, [8] bus_active, zero fill
   input  logic [OP_W-1:0]      req_tuser,   // [2:0] operation
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [2:0] bus_state, [10:3] data_byte,
                                             // [15:11] byte_count, [23:16] capture_time
   output logic                 rsp_tuser,   // [0] packet_valid
   output logic                 rsp_tlast,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   typedef enum logic {
      ST_ACCEPT,
      ST_READ
   } ctrl_type;

   // Configuration registers
   logic [TICK_W-1:0] bit_min_ff, bit_max_ff, one_max_ff, sof_min_ff, sof_max_ff;

   // Receiver state
   ctrl_type            ctrl_ff, ctrl_in;
   logic [STATE_W-1:0]  frame_state_ff, frame_state_in;
   logic [7:0]          shift_byte_ff, shift_byte_in;
   logic [3:0]          bit_counter_ff, bit_counter_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic [LEN_W-1:0]    slot_length_ff [PACKET_SLOTS];
   logic [TICK_W-1:0]   slot_time_ff [PACKET_SLOTS];
   logic                len_we, time_we;

   // Read-out sequencer
   logic [SLOT_W-1:0]   rd_slot_ff, rd_slot_in;
   logic [LEN_W-1:0]    rd_count_ff, rd_count_in;
   logic [TICK_W-1:0]   rd_time_ff, rd_time_in;
   logic [LEN_W-1:0]    rd_issue_ff, rd_issue_in;
   logic [LEN_W-1:0]    rd_out_ff, rd_out_in;
   logic                pend_ff, pend_in;

   // Packet memory
   logic [7:0]          packet_store_ff [MEM_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [7:0]          mem_wdata;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   logic                rsp_pkt_ff, rsp_pkt_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [TICK_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                rsp_last_ff, rsp_last_in;

   // Decode helpers
   logic                out_free, req_fire, move, issue, last_move;
   logic [OP_W-1:0]     op;
   logic [TICK_W-1:0]   ticks;
   logic                active, in_bit, in_sof, bit_val;
   logic [7:0]          shift_next;
   logic [3:0]          bc_inc;
   logic [BYTE_W-1:0]   byte_idx;
   logic [LEN_W-1:0]    head_len;
   logic [SLOT_W-1:0]   write_slot_next, read_slot_next;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (ctrl_ff == ST_ACCEPT) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign op     = req_tuser;
   assign ticks  = req_tdata[TICK_W-1:0];
   assign active = req_tdata[TICK_W];

   assign in_bit     = (ticks >= bit_min_ff) && (ticks <= bit_max_ff);
   assign in_sof     = (ticks >= sof_min_ff) && (ticks <= sof_max_ff);
   assign bit_val    = ticks <= one_max_ff;
   assign shift_next = {shift_byte_ff[6:0], bit_val};
   assign bc_inc     = bit_counter_ff + 4'd1;
   assign byte_idx   = (cur_len_ff < LEN_W'(PACKET_BYTES)) ? cur_len_ff[BYTE_W-1:0]
                                                           : BYTE_W'(PACKET_BYTES - 1);
   assign head_len   = slot_length_ff[read_slot_ff];

   assign write_slot_next = (write_slot_ff == SLOT_W'(PACKET_SLOTS - 1)) ? '0
                                                                         : write_slot_ff + 1'b1;
   assign read_slot_next  = (read_slot_ff == SLOT_W'(PACKET_SLOTS - 1)) ? '0
                                                                        : read_slot_ff + 1'b1;

   // Read-out handshake between memory output and response register
   assign move      = (ctrl_ff == ST_READ) && pend_ff && out_free;
   assign issue     = (ctrl_ff == ST_READ) && (rd_issue_ff != rd_count_ff)
                      && (!pend_ff || move);
   assign last_move = move && (rd_out_ff == rd_count_ff - 1'b1);
   assign mem_re    = issue;
   assign mem_raddr = {rd_slot_ff, rd_issue_ff[BYTE_W-1:0]};

   // Next-state logic
   always_comb begin
      ctrl_in        = ctrl_ff;
      frame_state_in = frame_state_ff;
      shift_byte_in  = shift_byte_ff;
      bit_counter_in = bit_counter_ff;
      cur_len_in     = cur_len_ff;
      write_slot_in  = write_slot_ff;
      read_slot_in   = read_slot_ff;
      len_we         = 1'b0;
      time_we        = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = {write_slot_ff, byte_idx};
      mem_wdata      = shift_next;
      rd_slot_in     = rd_slot_ff;
      rd_count_in    = rd_count_ff;
      rd_time_in     = rd_time_ff;
      rd_issue_in    = rd_issue_ff + LEN_W'(issue);
      rd_out_in      = rd_out_ff + LEN_W'(move);
      pend_in        = issue || (pend_ff && !move);
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_state_in   = rsp_state_ff;
      rsp_pkt_in     = rsp_pkt_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_last_in    = rsp_last_ff;

      if (req_fire) begin
         unique case (op)
            OP_RISE: begin
               if (frame_state_ff > BUS_DATA) time_we = 1'b1;
            end
            OP_FALL: begin
               // shift in a bit, close a byte at eight bits
               if (in_bit) begin
                  frame_state_in = BUS_DATA;
                  shift_byte_in  = shift_next;
                  bit_counter_in = bc_inc;
                  if (bc_inc >= BITS_PER_BYTE) begin
                     mem_we         = 1'b1;
                     bit_counter_in = '0;
                     if (cur_len_ff < LEN_W'(PACKET_BYTES)) cur_len_in = cur_len_ff + 1'b1;
                  end
               end
               if (in_sof) begin
                  frame_state_in = BUS_SOF;
                  bit_counter_in = '0;
               end
            end
            OP_EOD: begin
               // close a non-empty packet into the ring
               if (active) begin
                  frame_state_in = BUS_ERROR;
               end else if (frame_state_ff < BUS_EOD) begin
                  frame_state_in = BUS_EOD;
                  cur_len_in     = '0;
                  if (cur_len_ff != '0) begin
                     len_we        = 1'b1;
                     write_slot_in = write_slot_next;
                  end
               end
            end
            OP_EOF:  frame_state_in = active ? BUS_ERROR : BUS_EOF;
            OP_IDLE: frame_state_in = active ? BUS_ERROR : BUS_IDLE;
            OP_READ: begin
               if (write_slot_ff != read_slot_ff) begin
                  read_slot_in = read_slot_next;
                  if (head_len != '0) begin
                     ctrl_in     = ST_READ;
                     rd_slot_in  = read_slot_ff;
                     rd_count_in = head_len;
                     rd_time_in  = slot_time_ff[read_slot_ff];
                     rd_issue_in = '0;
                     rd_out_in   = '0;
                     pend_in     = 1'b0;
                  end
               end
            end
            default: ;
         endcase

         // status word for all but a packet read
         if (!((op == OP_READ) && (write_slot_ff != read_slot_ff) && (head_len != '0))) begin
            rsp_valid_in = 1'b1;
            rsp_state_in = frame_state_in;
            rsp_pkt_in   = 1'b0;
            rsp_byte_in  = '0;
            rsp_count_in = '0;
            rsp_time_in  = '0;
            rsp_last_in  = 1'b1;
         end
      end

      // stream packet bytes into the response register
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = frame_state_ff;
         rsp_pkt_in   = 1'b1;
         rsp_byte_in  = rd_data_ff;
         rsp_count_in = COUNT_W'(rd_count_ff);
         rsp_time_in  = rd_time_ff;
         rsp_last_in  = last_move;
         if (last_move) ctrl_in = ST_ACCEPT;
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= ST_ACCEPT;
         frame_state_ff <= BUS_UNKNOWN;
         shift_byte_ff  <= '0;
         bit_counter_ff <= '0;
         cur_len_ff     <= '0;
         write_slot_ff  <= '0;
         read_slot_ff   <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         bit_min_ff     <= RST_BIT_MIN;
         bit_max_ff     <= RST_BIT_MAX;
         one_max_ff     <= RST_ONE_MAX;
         sof_min_ff     <= RST_SOF_MIN;
         sof_max_ff     <= RST_SOF_MAX;
      end else begin
         ctrl_ff        <= ctrl_in;
         frame_state_ff <= frame_state_in;
         shift_byte_ff  <= shift_byte_in;
         bit_counter_ff <= bit_counter_in;
         cur_len_ff     <= cur_len_in;
         write_slot_ff  <= write_slot_in;
         read_slot_ff   <= read_slot_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         // configuration writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_BIT_MIN: bit_min_ff <= csr_data;
               REG_BIT_MAX: bit_max_ff <= csr_data;
               REG_ONE_MAX: one_max_ff <= csr_data;
               REG_SOF_MIN: sof_min_ff <= csr_data;
               REG_SOF_MAX: sof_max_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Slot capture times, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PACKET_SLOTS; i++) slot_time_ff[i] <= '0;
      end else if (time_we) begin
         slot_time_ff[write_slot_ff] <= ticks;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (len_we) slot_length_ff[write_slot_ff] <= cur_len_ff;
      rd_slot_ff   <= rd_slot_in;
      rd_count_ff  <= rd_count_in;
      rd_time_ff   <= rd_time_in;
      rd_issue_ff  <= rd_issue_in;
      rd_out_ff    <= rd_out_in;
      rsp_state_ff <= rsp_state_in;
      rsp_pkt_ff   <= rsp_pkt_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_count_ff <= rsp_count_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Packet memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) packet_store_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= packet_store_ff[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_count_ff, rsp_byte_ff, rsp_state_ff};
   assign rsp_tuser  = rsp_pkt_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Read-out sequencer never runs on an empty packet
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == ST_READ) |-> (rd_count_ff != '0))
      else $error("read-out active with zero byte count");

   // Memory data pending only while reading
   a_pend_in_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (ctrl_ff == ST_READ))
      else $error("memory data pending outside read-out");

   // Bytes delivered never pass bytes fetched
   a_out_le_issue: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == ST_READ) |-> (rd_out_ff <= rd_issue_ff && rd_issue_ff <= rd_count_ff))
      else $error("read-out counters out of order");

   // A packet read moves the read slot on by one
   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && op == OP_READ && write_slot_ff != read_slot_ff)
      |=> (read_slot_ff != $past(read_slot_ff)))
      else $error("read slot did not advance");

   // Bit counter stays within one byte
   a_bit_counter: assert property (@(posedge clock) disable iff (reset)
      bit_counter_ff < BITS_PER_BYTE)
      else $error("bit counter past a full byte");

endmodule

>>> dv/tb_j1850_pwm_frame_receiver_top.sv
// Self-checking testbench for the J1850 PWM frame receiver: event stream in, status and packet bytes out.
`timescale 1ns / 100ps

module tb_j1850_pwm_frame_receiver_top;
   import j1850_pkg::*;

   // Operation codes the block does not use, and a register index past the list
   localparam logic [OP_W-1:0]      OP_SPARE_LO  = 3'd6;
   localparam logic [OP_W-1:0]      OP_SPARE_HI  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED   = 3'd7;
   localparam int                   RANDOM_ITEMS = 24;
   localparam int                   DRAIN_CYCLES = PACKET_BYTES + 8;

   typedef struct packed {
      logic [STATE_W-1:0] bus_state;
      logic               packet_valid;
      logic [7:0]         data_byte;
      logic [COUNT_W-1:0] byte_count;
      logic [TICK_W-1:0]  capture_time;
      logic               last;
   } rx_word_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // [7:0] elapsed_ticks, [8] bus_active, zero fill
   logic [OP_W-1:0]      req_tuser  = '0;   // [2:0] operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;         // [2:0] bus_state, [10:3] data_byte,
                                            // [15:11] byte_count, [23:16] capture_time
   logic                 rsp_tuser;         // [0] packet_valid
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TICK_W-1:0]    csr_data   = '0;

   // Hold both sides busy when set
   bit steady = 1'b0;

   // Decoder copy: timing windows
   logic [7:0] win_bit_lo = RST_BIT_MIN;
   logic [7:0] win_bit_hi = RST_BIT_MAX;
   logic [7:0] one_hi     = RST_ONE_MAX;
   logic [7:0] win_sof_lo = RST_SOF_MIN;
   logic [7:0] win_sof_hi = RST_SOF_MAX;

   // Decoder copy: frame state and packet ring
   logic [STATE_W-1:0] bus_now   = BUS_UNKNOWN;
   logic [7:0]         shifter   = '0;
   logic [3:0]         bits_seen = '0;
   logic [LEN_W-1:0]   bytes_open = '0;
   logic [SLOT_W-1:0]  slot_wr   = '0;
   logic [SLOT_W-1:0]  slot_rd   = '0;
   logic [7:0]         byte_mem  [MEM_DEPTH];
   logic [LEN_W-1:0]   len_mem   [PACKET_SLOTS];
   logic [7:0]         stamp_mem [PACKET_SLOTS] = '{default: '0};

   rx_word_type expected_words [$];

   int items_sent     = 0;
   int words_checked  = 0;
   int bytes_checked  = 0;
   int reg_writes     = 0;
   int mismatch_count = 0;

   j1850_pwm_frame_receiver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Stall the response side about a third of the time
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 35);
   end

   // Advance the decoder copy by one event and queue the words it answers with
   function automatic void decode_event(input logic [OP_W-1:0] op, input logic [7:0] t,
                                        input logic active);
      int          idx;
      int          n;
      int          base;
      int          i;
      rx_word_type w;
      case (op)
         OP_RISE: begin
            if (bus_now > BUS_DATA) stamp_mem[slot_wr] = t;
         end
         OP_FALL: begin
            // A pulse in both windows shifts the bit first, then restarts the frame
            if (t >= win_bit_lo && t <= win_bit_hi) begin
               bus_now   = BUS_DATA;
               shifter   = {shifter[6:0], (t <= one_hi)};
               bits_seen = bits_seen + 4'd1;
               if (bits_seen >= BITS_PER_BYTE) begin
                  idx = (bytes_open < PACKET_BYTES) ? int'(bytes_open) : PACKET_BYTES - 1;
                  byte_mem[slot_wr * PACKET_BYTES + idx] = shifter;
                  if (bytes_open < PACKET_BYTES) bytes_open = bytes_open + 1'b1;
                  bits_seen = '0;
               end
            end
            if (t >= win_sof_lo && t <= win_sof_hi) begin
               bus_now   = BUS_SOF;
               bits_seen = '0;
            end
         end
         OP_EOD: begin
            if (active) begin
               bus_now = BUS_ERROR;
            end else if (bus_now < BUS_EOD) begin
               bus_now = BUS_EOD;
               if (bytes_open > 0) begin
                  len_mem[slot_wr] = bytes_open;
                  slot_wr = SLOT_W'((slot_wr + 1) % PACKET_SLOTS);
               end
               bytes_open = '0;
            end
         end
         OP_EOF: begin
            bus_now = active ? BUS_ERROR : BUS_EOF;
         end
         OP_IDLE: begin
            bus_now = active ? BUS_ERROR : BUS_IDLE;
         end
         OP_READ: begin
            if (slot_wr != slot_rd) begin
               n    = (len_mem[slot_rd] > PACKET_BYTES) ? PACKET_BYTES : int'(len_mem[slot_rd]);
               base = slot_rd * PACKET_BYTES;
               for (i = 0; i < n; i++) begin
                  w.bus_state    = bus_now;
                  w.packet_valid = 1'b1;
                  w.data_byte    = byte_mem[base + i];
                  w.byte_count   = COUNT_W'(n);
                  w.capture_time = stamp_mem[slot_rd];
                  w.last         = (i + 1 == n);
                  expected_words.push_back(w);
               end
               slot_rd = SLOT_W'((slot_rd + 1) % PACKET_SLOTS);
               if (n > 0) return;
            end
         end
         default: ;
      endcase
      // Everything else answers with one status word
      w           = '0;
      w.bus_state = bus_now;
      w.last      = 1'b1;
      expected_words.push_back(w);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted response word with the oldest queued one
   always @(posedge clock) begin
      rx_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("response word with none queued: tdata %h, tuser %b, tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("bus_state", want.bus_state, rsp_tdata[2:0]);
            check_field("packet_valid", want.packet_valid, rsp_tuser);
            check_field("data_byte", want.data_byte, rsp_tdata[10:3]);
            check_field("byte_count", want.byte_count, rsp_tdata[15:11]);
            check_field("capture_time", want.capture_time, rsp_tdata[23:16]);
            check_field("last", want.last, rsp_tlast);
            if (want.packet_valid) bytes_checked++;
         end
         words_checked++;
      end
   end

   // Present one event word, idling first at random, and wait for it to be taken
   task automatic send_event(input logic [OP_W-1:0] op, input logic [7:0] ticks,
                             input logic active);
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, active, ticks};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_event(op, ticks, active);
      items_sent++;
   endtask

   // Drop valid and wait until every queued word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_BIT_MIN: win_bit_lo = val;
         REG_BIT_MAX: win_bit_hi = val;
         REG_ONE_MAX: one_hi     = val;
         REG_SOF_MIN: win_sof_lo = val;
         REG_SOF_MAX: win_sof_hi = val;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic write_defaults();
      write_reg(REG_BIT_MIN, RST_BIT_MIN);
      write_reg(REG_BIT_MAX, RST_BIT_MAX);
      write_reg(REG_ONE_MAX, RST_ONE_MAX);
      write_reg(REG_SOF_MIN, RST_SOF_MIN);
      write_reg(REG_SOF_MAX, RST_SOF_MAX);
   endtask

   // Pulse width for one data bit under the current windows
   function automatic logic [7:0] bit_ticks(input logic one);
      if (one) return 8'($urandom_range(one_hi, win_bit_lo));
      return 8'($urandom_range(win_bit_hi, one_hi + 1));
   endfunction

   task automatic send_noise();
      send_event(OP_W'($urandom_range(7)), 8'($urandom), 1'($urandom));
   endtask

   // Idle, capture edge, SOF, then nbytes of random bits, end of data and at random end of frame
   task automatic send_frame(input int nbytes, input bit noisy);
      logic [7:0] value;
      int         b;
      int         k;
      send_event(OP_IDLE, 8'($urandom), 1'b0);
      send_event(OP_RISE, 8'($urandom), 1'b0);
      send_event(OP_FALL, 8'($urandom_range(win_sof_hi, win_sof_lo)), 1'b0);
      for (b = 0; b < nbytes; b++) begin
         value = 8'($urandom);
         for (k = 7; k >= 0; k--) begin
            if (noisy && $urandom_range(99) < 4) send_noise();
            if ($urandom_range(99) < 10) send_event(OP_RISE, 8'($urandom), 1'b0);
            send_event(OP_FALL, bit_ticks(value[k]), 1'b0);
         end
      end
      send_event(OP_EOD, 8'($urandom), 1'b0);
      if ($urandom_range(1)) send_event(OP_EOF, 8'($urandom), 1'b0);
   endtask

   // Reset windows: every operation, window edges, error timeouts, repeated end of data
   task automatic test_directed();
      int seq [8] = '{14, 39, 24, 20, 25, 30, 14, 39};
      int i;
      send_event(OP_READ, 8'h00, 1'b0);
      send_event(OP_RISE, 8'hFF, 1'b0);
      send_event(OP_IDLE, 8'h00, 1'b0);
      send_event(OP_RISE, 8'hA5, 1'b0);
      send_event(OP_FALL, 8'd63, 1'b0);
      for (i = 0; i < 8; i++) send_event(OP_FALL, 8'(seq[i]), 1'b0);
      send_event(OP_FALL, 8'h00, 1'b0);
      send_event(OP_FALL, 8'hFF, 1'b0);
      send_event(OP_EOD, 8'h00, 1'b1);
      send_event(OP_EOD, 8'h00, 1'b0);
      send_event(OP_EOD, 8'h00, 1'b0);
      send_event(OP_RISE, 8'h5A, 1'b0);
      send_event(OP_EOF, 8'h00, 1'b1);
      send_event(OP_EOF, 8'h00, 1'b0);
      send_event(OP_IDLE, 8'h00, 1'b1);
      send_event(OP_SPARE_LO, 8'hFF, 1'b1);
      send_event(OP_SPARE_HI, 8'h00, 1'b0);
      send_event(OP_READ, 8'hFF, 1'b1);
      send_event(OP_READ, 8'h00, 1'b0);
   endtask

   // Window extremes: overlapping bit and SOF windows, empty bit window
   task automatic test_window_corners();
      logic [7:0] pattern;
      int         k;
      write_reg(REG_BIT_MIN, 8'h00);
      write_reg(REG_BIT_MAX, 8'hFF);
      write_reg(REG_ONE_MAX, 8'hFF);
      send_event(OP_IDLE, 8'h00, 1'b0);
      send_event(OP_RISE, 8'h3C, 1'b0);
      send_event(OP_FALL, 8'd61, 1'b0);
      for (k = 0; k < 8; k++) send_event(OP_FALL, 8'($urandom_range(59)), 1'b0);

      write_reg(REG_ONE_MAX, 8'h00);
      write_reg(REG_SOF_MIN, 8'hFF);
      write_reg(REG_SOF_MAX, 8'hFF);
      pattern = 8'h96;
      send_event(OP_FALL, 8'hFF, 1'b0);
      for (k = 7; k >= 0; k--)
         send_event(OP_FALL, pattern[k] ? 8'h00 : 8'($urandom_range(254, 1)), 1'b0);
      send_event(OP_EOD, 8'h00, 1'b0);

      write_reg(REG_BIT_MIN, 8'hFF);
      write_reg(REG_BIT_MAX, 8'h00);
      write_reg(REG_SOF_MIN, 8'h00);
      write_reg(REG_SOF_MAX, 8'h00);
      write_reg(REG_UNUSED, 8'hFF);
      send_event(OP_FALL, 8'h00, 1'b0);
      send_event(OP_FALL, 8'd200, 1'b0);
      send_event(OP_READ, 8'h00, 1'b0);
      send_event(OP_READ, 8'h00, 1'b0);
      write_defaults();
   endtask

   // Close more packets than the ring holds, with no idling on either side
   task automatic test_ring_overflow();
      int p;
      steady = 1'b1;
      for (p = 0; p < PACKET_SLOTS; p++) send_frame(1, 1'b0);
      send_event(OP_READ, 8'h00, 1'b0);
      send_frame(1, 1'b0);
      repeat (2) send_event(OP_READ, 8'h00, 1'b0);
      steady = 1'b0;
   endtask

   // Overrun packet: the first sixteen bytes fill it, the rest overwrite its last byte
   task automatic test_long_packets();
      send_frame(PACKET_BYTES + 1, 1'b0);
      repeat (2) send_event(OP_READ, 8'h00, 1'b0);
   endtask

   // Mostly well-formed frames with noise, under random and then reset windows
   task automatic test_random_traffic();
      int start_count;
      int roll;
      int lo;
      int one;
      int hi;
      int sof;
      lo  = $urandom_range(20, 5);
      one = lo + $urandom_range(15, 3);
      hi  = one + $urandom_range(20, 3);
      sof = hi + $urandom_range(30, 5);
      write_reg(REG_BIT_MIN, 8'(lo));
      write_reg(REG_ONE_MAX, 8'(one));
      write_reg(REG_BIT_MAX, 8'(hi));
      write_reg(REG_SOF_MIN, 8'(sof));
      write_reg(REG_SOF_MAX, 8'(sof + $urandom_range(10)));
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if (items_sent - start_count >= RANDOM_ITEMS / 2 && win_bit_lo != RST_BIT_MIN)
            write_defaults();
         roll = $urandom_range(99);
         if (roll < 60)
            send_frame($urandom_range(2, 1), $urandom_range(99) < 30);
         else if (roll < 80)
            send_event(OP_READ, 8'($urandom), 1'($urandom));
         else
            repeat ($urandom_range(4, 1)) send_noise();
      end
      repeat (PACKET_SLOTS) send_event(OP_READ, 8'h00, 1'b0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_window_corners();
      test_ring_overflow();
      test_long_packets();
      test_random_traffic();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bus events; checked %0d response words, %0d of them packet bytes.",
               items_sent, words_checked, bytes_checked);
      $display("Made %0d register writes over reset, corner and random timing windows.",
               reg_writes);
      if (mismatch_count == 0) begin
         $display("** j1850_pwm_frame_receiver_top: PASSED **");
      end else begin
         $display("** j1850_pwm_frame_receiver_top: FAILED **");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #1_000_000;
      $display("** j1850_pwm_frame_receiver_top: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
src/j1850_pkg.sv
src/j1850_pwm_frame_receiver_top.sv
dv/tb_j1850_pwm_frame_receiver_top.sv
